// File: design/tdpt_pkg.sv
// Package for the trial-division prime test core: field widths, fixed divisors
// and the command/status structs between controller and datapath.
// No dependencies.
package tdpt_pkg;

    localparam int CAND_W   = 32;   // width of the candidate port
    localparam int FACTOR_W = 16;   // width of the reported factor

    localparam int FIRST_ODD_DIVISOR = 3;
    localparam int EVEN_DIVISOR      = 2;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture a new number, divisor back to three
        logic start_div;  // clear remainder, point at the top bit
        logic step_div;   // one restoring-division bit
        logic advance;    // divisor += 2, square kept in step
    } tdpt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic                num_lt2;
        logic                num_two;
        logic                num_even;
        logic                sq_gt_num;   // divisor squared above the number
        logic                rem_zero;
        logic                div_last;    // current division bit is bit 0
        logic [FACTOR_W-1:0] factor;      // current divisor, low bits
    } tdpt_stat_t;

endpackage

// File: design/trial_division_prime_test_core.sv
// Top level of the trial-division prime test core: controller plus datapath.
// Depends on tdpt_pkg, tdpt_ctrl and tdpt_datapath.
//
//  channel | ports                                     | direction
//  --------+-------------------------------------------+----------
//  input   | s_valid s_ready s_candidate[31:0]         | in
//  result  | m_valid m_ready m_is_prime                | out
//          | m_smallest_factor[15:0]                   |
//
// Flow: one item at a time. Numbers below 3 and even numbers are settled in
// the check state and go on to the output register. Otherwise each odd
// divisor tried takes a square compare, one remainder bit per cycle and a
// remainder test, set by the bit-serial remainder unit; the item ends when a
// divisor divides the number or when the divisor squared is above the number.
// Reset: synchronous on aresetn low; control and output valid clear.
// Stalls: a finished result sits in the output register while the next item
// is accepted; a second result waits in the controller until the slot frees.
module trial_division_prime_test_core import tdpt_pkg::*; #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CAND_W-1:0]   s_candidate,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_is_prime,
    output logic [FACTOR_W-1:0] m_smallest_factor
);

    // command and status between sequencer and datapath
    tdpt_cmd_t  cmd;
    tdpt_stat_t stat;

    // sequencer: classifies the number, runs one divisor at a time,
    // owns the output register
    tdpt_ctrl u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_is_prime        (m_is_prime),
        .m_smallest_factor (m_smallest_factor),
        .cmd               (cmd),
        .stat              (stat)
    );

    // datapath: held number, odd divisor with its running square, and the
    // restoring remainder unit (square compare replaces the sqrt bound)
    tdpt_datapath #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .candidate (s_candidate),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: design/tdpt_datapath.sv
// Datapath of the trial-division prime test: number, odd divisor, its square
// and a bit-serial restoring remainder unit. Depends on tdpt_pkg.
module tdpt_datapath import tdpt_pkg::*; #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                aclk,
    input  logic [CAND_W-1:0]   candidate,
    input  tdpt_cmd_t           cmd,
    output tdpt_stat_t          stat
);

    localparam int W  = NUMBER_WIDTH;
    localparam int DW = (W + 1) / 2 + 1;   // holds every divisor tried
    localparam int SW = 2 * DW;            // holds its square
    localparam int CW = $clog2(W);

    logic [W-1:0]  num_reg;
    logic [DW-1:0] div_reg;
    logic [SW-1:0] sq_reg;
    logic [DW-1:0] rem_reg;
    logic [CW-1:0] bit_idx_reg;

    logic [W+CAND_W-1:0]   cand_ext;
    logic [DW:0]           rem_shift;
    logic [DW:0]           rem_diff;
    logic [DW+FACTOR_W-1:0] div_ext;

    assign cand_ext  = {{W{1'b0}}, candidate};
    assign rem_shift = {rem_reg, num_reg[bit_idx_reg]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign div_ext   = {{FACTOR_W{1'b0}}, div_reg};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            num_reg <= cand_ext[W-1:0];
            div_reg <= DW'(FIRST_ODD_DIVISOR);
            sq_reg  <= SW'(FIRST_ODD_DIVISOR * FIRST_ODD_DIVISOR);
        end else if (cmd.advance) begin
            div_reg <= div_reg + DW'(2);
            // (d+2)^2 = d^2 + 4d + 4
            sq_reg  <= sq_reg + SW'({div_reg, 2'b00}) + SW'(4);
        end
        if (cmd.start_div) begin
            rem_reg     <= '0;
            bit_idx_reg <= CW'(W - 1);
        end else if (cmd.step_div) begin
            rem_reg     <= rem_diff[DW] ? rem_shift[DW-1:0] : rem_diff[DW-1:0];
            bit_idx_reg <= bit_idx_reg - CW'(1);
        end
    end

    always_comb begin
        stat.num_lt2   = (num_reg[W-1:1] == '0);
        stat.num_two   = (num_reg == W'(EVEN_DIVISOR));
        stat.num_even  = ~num_reg[0];
        stat.sq_gt_num = (sq_reg > SW'(num_reg));
        stat.rem_zero  = (rem_reg == '0);
        stat.div_last  = (bit_idx_reg == '0);
        stat.factor    = div_ext[FACTOR_W-1:0];
    end

endmodule

// File: design/tdpt_ctrl.sv
// Controller of the trial-division prime test: sequencing state machine,
// pending result and the output register. Depends on tdpt_pkg.
module tdpt_ctrl import tdpt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_is_prime,
    output logic [FACTOR_W-1:0] m_smallest_factor,
    output tdpt_cmd_t           cmd,
    input  tdpt_stat_t          stat
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_TEST   = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                res_prime_reg, res_prime_next;
    logic [FACTOR_W-1:0] res_factor_reg, res_factor_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_prime_reg, m_prime_next;
    logic [FACTOR_W-1:0] m_factor_reg, m_factor_next;
    logic                out_free;

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_is_prime        = m_prime_reg;
    assign m_smallest_factor = m_factor_reg;
    assign out_free          = ~m_valid_reg | m_ready;

    always_comb begin
        state_next      = state_reg;
        res_prime_next  = res_prime_reg;
        res_factor_next = res_factor_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_prime_next    = m_prime_reg;
        m_factor_next   = m_factor_reg;
        cmd             = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.num_lt2) begin
                    res_prime_next  = 1'b0;
                    res_factor_next = '0;
                    state_next      = ST_RESULT;
                end else if (stat.num_two) begin
                    res_prime_next  = 1'b1;
                    res_factor_next = '0;
                    state_next      = ST_RESULT;
                end else if (stat.num_even) begin
                    res_prime_next  = 1'b0;
                    res_factor_next = FACTOR_W'(EVEN_DIVISOR);
                    state_next      = ST_RESULT;
                end else if (stat.sq_gt_num) begin
                    res_prime_next  = 1'b1;
                    res_factor_next = '0;
                    state_next      = ST_RESULT;
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step_div = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (stat.rem_zero) begin
                    res_prime_next  = 1'b0;
                    res_factor_next = stat.factor;
                    state_next      = ST_RESULT;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_prime_next  = res_prime_reg;
                    m_factor_next = res_factor_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        res_prime_reg  <= res_prime_next;
        res_factor_reg <= res_factor_next;
        m_prime_reg    <= m_prime_next;
        m_factor_reg   <= m_factor_next;
    end

    a_accept_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CHECK))
        else $error("accepted item did not start a test");

    a_new_result_from_result_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_RESULT))
        else $error("output valid raised outside result hand-off");

    a_prime_has_no_factor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_prime_reg) |-> (m_factor_reg == '0))
        else $error("prime result carries a factor");

    a_division_ends_in_test: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && stat.div_last) |=> (state_reg == ST_TEST))
        else $error("division pass did not end in remainder test");

endmodule
